FILE: rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

  // Hue sector, chosen by the largest channel (red wins ties, then green).
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // Control fields that travel with each transaction down the chain.
  typedef struct packed {
    logic    valid;
    logic    gray;
    logic    neg;
    sector_e sector;
  } ctrl_t;

  localparam int unsigned ThrBits  = 8;
  localparam int unsigned SatBits  = 16;
  localparam int unsigned AddrBits = 3;
  localparam int unsigned DataBits = 32;

  localparam logic [ThrBits-1:0] ThrReset = 8'd1;

  // Register index taken from paddr[AddrBits-1:2].
  localparam logic [AddrBits-3:0] RegGrayThreshold = 1'b0;

endpackage

FILE: rtl/rgbhsl_prep.sv
// Front stage: max/min, chroma, lightness, sector and first quotient bits.
module rgbhsl_prep #(
  parameter int unsigned CW = 8,
  parameter int unsigned QW = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         ready_i,
  input  logic                         valid_i,
  input  logic [CW-1:0]                red_i,
  input  logic [CW-1:0]                green_i,
  input  logic [CW-1:0]                blue_i,
  input  logic [rgbhsl_pkg::ThrBits-1:0] thr_i,
  output rgbhsl_pkg::ctrl_t            ctrl_o,
  output logic [CW:0]                  sum_o,
  output logic [CW-1:0]                sat_rem_o,
  output logic [CW-1:0]                sat_den_o,
  output logic [QW-1:0]                sat_q_o,
  output logic [CW-1:0]                hue_rem_o,
  output logic [CW-1:0]                hue_div_o,
  output logic [QW-1:0]                hue_q_o
);

  localparam int unsigned TW = (CW > rgbhsl_pkg::ThrBits) ? CW : rgbhsl_pkg::ThrBits;

  logic [CW-1:0] mx, mn, d, den, pos, subt, mag, sat_rem, hue_rem;
  logic [CW-1:0] full;
  logic [CW:0]   sum, den_w;
  logic [TW-1:0] d_ext, thr_ext;
  logic [rgbhsl_pkg::ThrBits-1:0] thr_eff;
  logic          neg, gray, sat_top, hue_top;
  rgbhsl_pkg::sector_e sector;

  rgbhsl_pkg::ctrl_t ctrl_q;
  logic [CW:0]       sum_q;
  logic [CW-1:0]     sat_rem_q, sat_den_q, hue_rem_q, hue_div_q;
  logic [QW-1:0]     sat_q_q, hue_q_q;

  always_comb begin
    full = {CW{1'b1}};
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    if (sum < {1'b0, full}) begin
      den_w = sum;
    end else begin
      den_w = {full, 1'b0} - sum;
    end
    den = den_w[CW-1:0];

    // red, then green, then blue on ties
    if (red_i == mx) begin
      sector = rgbhsl_pkg::SECT_RED;
      pos    = green_i;
      subt   = blue_i;
    end else if (green_i == mx) begin
      sector = rgbhsl_pkg::SECT_GREEN;
      pos    = blue_i;
      subt   = red_i;
    end else begin
      sector = rgbhsl_pkg::SECT_BLUE;
      pos    = red_i;
      subt   = green_i;
    end
    neg = subt > pos;
    mag = neg ? (subt - pos) : (pos - subt);

    // threshold of zero acts as one
    thr_eff = (thr_i == '0) ? rgbhsl_pkg::ThrBits'(1) : thr_i;
    d_ext   = TW'(d);
    thr_ext = TW'(thr_eff);
    gray    = d_ext < thr_ext;

    // integer bit of each quotient; both quotients are at most one
    sat_top = d >= den;
    sat_rem = sat_top ? (d - den) : d;
    hue_top = mag >= d;
    hue_rem = hue_top ? (mag - d) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (ready_i) begin
      ctrl_q.valid  <= valid_i;
      ctrl_q.gray   <= gray;
      ctrl_q.neg    <= neg;
      ctrl_q.sector <= sector;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i) begin
      sum_q     <= sum;
      sat_rem_q <= sat_rem;
      sat_den_q <= den;
      sat_q_q   <= QW'(sat_top);
      hue_rem_q <= hue_rem;
      hue_div_q <= d;
      hue_q_q   <= QW'(hue_top);
    end
  end

  assign ctrl_o    = ctrl_q;
  assign sum_o     = sum_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_den_o = sat_den_q;
  assign sat_q_o   = sat_q_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign hue_q_o   = hue_q_q;

endmodule

FILE: rtl/rgbhsl_div_cell.sv
// One restoring-division step for both the saturation and hue quotients.
module rgbhsl_div_cell #(
  parameter int unsigned CW = 8,
  parameter int unsigned QW = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ready_i,
  input  rgbhsl_pkg::ctrl_t ctrl_i,
  input  logic [CW:0]       sum_i,
  input  logic [CW-1:0]     sat_rem_i,
  input  logic [CW-1:0]     sat_den_i,
  input  logic [QW-1:0]     sat_q_i,
  input  logic [CW-1:0]     hue_rem_i,
  input  logic [CW-1:0]     hue_div_i,
  input  logic [QW-1:0]     hue_q_i,
  output rgbhsl_pkg::ctrl_t ctrl_o,
  output logic [CW:0]       sum_o,
  output logic [CW-1:0]     sat_rem_o,
  output logic [CW-1:0]     sat_den_o,
  output logic [QW-1:0]     sat_q_o,
  output logic [CW-1:0]     hue_rem_o,
  output logic [CW-1:0]     hue_div_o,
  output logic [QW-1:0]     hue_q_o
);

  logic [CW:0]   sat_t, hue_t, sat_sub, hue_sub;
  logic          sat_bit, hue_bit;

  rgbhsl_pkg::ctrl_t ctrl_q;
  logic [CW:0]       sum_q;
  logic [CW-1:0]     sat_rem_q, sat_den_q, hue_rem_q, hue_div_q;
  logic [QW-1:0]     sat_q_q, hue_q_q;

  // remainder stays below the divisor, so the doubled value fits CW+1 bits
  always_comb begin
    sat_t   = {sat_rem_i, 1'b0};
    sat_bit = sat_t >= {1'b0, sat_den_i};
    sat_sub = sat_t - {1'b0, sat_den_i};
    hue_t   = {hue_rem_i, 1'b0};
    hue_bit = hue_t >= {1'b0, hue_div_i};
    hue_sub = hue_t - {1'b0, hue_div_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (ready_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i) begin
      sum_q     <= sum_i;
      sat_den_q <= sat_den_i;
      hue_div_q <= hue_div_i;
      sat_rem_q <= sat_bit ? sat_sub[CW-1:0] : sat_t[CW-1:0];
      hue_rem_q <= hue_bit ? hue_sub[CW-1:0] : hue_t[CW-1:0];
      sat_q_q   <= {sat_q_i[QW-2:0], sat_bit};
      hue_q_q   <= {hue_q_i[QW-2:0], hue_bit};
    end
  end

  assign ctrl_o    = ctrl_q;
  assign sum_o     = sum_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_den_o = sat_den_q;
  assign sat_q_o   = sat_q_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign hue_q_o   = hue_q_q;

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// Top level of the pipelined RGB to HSL pixel converter.
//
// Converts one RGB pixel per clock unless stalled. A transaction passes
// a front stage (max/min, chroma d, lightness sum, hue sector and the
// integer quotient bit), then a row of NCELLS = max(16, HUE_FRACTION_BITS)
// division cells, each resolving one fraction bit of both the saturation
// quotient d*2^16/den and the hue quotient |diff|*2^HUE_FRACTION_BITS/d,
// then the output register, which applies the sector offset (1, 3 or 5),
// saturates the saturation at 65535 and zeroes hue and saturation for
// gray pixels. Throughput is one transaction per cycle while out_stall_i
// is low, set by the one-bit-per-cell division row.
// Each stage holds its transaction only while the next one is full and
// stalled, so bubbles collapse and input stall only rises when the whole
// row is full. lightness_sum is max+min (lightness = lightness_sum / (2F)).
// Register gray_threshold at byte address 0 (8 bits, reset 1; zero acts
// as one): pixels with max - min below it are gray.
module rgb_to_hsl_converter #(
  parameter int unsigned CHANNEL_BITS      = 8,
  parameter int unsigned HUE_FRACTION_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB-style configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbhsl_pkg::AddrBits-1:0]     paddr,
  input  logic [rgbhsl_pkg::DataBits-1:0]     pwdata,
  output logic [rgbhsl_pkg::DataBits-1:0]     prdata,
  output logic                                pready,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [CHANNEL_BITS-1:0]             red_i,
  input  logic [CHANNEL_BITS-1:0]             green_i,
  input  logic [CHANNEL_BITS-1:0]             blue_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [HUE_FRACTION_BITS+2:0]        hue_o,
  output logic [rgbhsl_pkg::SatBits-1:0]      saturation_o,
  output logic [CHANNEL_BITS:0]               lightness_sum_o,
  output logic                                is_gray_o
);

  localparam int unsigned CW     = CHANNEL_BITS;
  localparam int unsigned FB     = HUE_FRACTION_BITS;
  localparam int unsigned SB     = rgbhsl_pkg::SatBits;
  localparam int unsigned HW     = FB + 3;
  localparam int unsigned NCELLS = (FB > SB) ? FB : SB;
  localparam int unsigned QW     = NCELLS + 1;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [rgbhsl_pkg::ThrBits-1:0] thr_q;
  logic                           reg_sel;

  assign reg_sel = paddr[rgbhsl_pkg::AddrBits-1:2] == rgbhsl_pkg::RegGrayThreshold;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rgbhsl_pkg::ThrReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_q <= pwdata[rgbhsl_pkg::ThrBits-1:0];
    end
  end

  assign prdata = reg_sel ? rgbhsl_pkg::DataBits'(thr_q) : '0;

  // ---------------------------------------------------------------------
  // Pipeline: stage 0 is the front stage, stages 1..NCELLS the cells
  // ---------------------------------------------------------------------
  rgbhsl_pkg::ctrl_t ctrl   [NCELLS+1];
  logic [CW:0]       sum    [NCELLS+1];
  logic [CW-1:0]     sat_rem[NCELLS+1];
  logic [CW-1:0]     sat_den[NCELLS+1];
  logic [QW-1:0]     sat_q  [NCELLS+1];
  logic [CW-1:0]     hue_rem[NCELLS+1];
  logic [CW-1:0]     hue_div[NCELLS+1];
  logic [QW-1:0]     hue_q  [NCELLS+1];
  logic              ready  [NCELLS+2];

  // a stage loads when it is empty or the stage after it loads
  logic out_valid_q;
  assign ready[NCELLS+1] = !out_valid_q || !out_stall_i;

  for (genvar k = 0; k <= NCELLS; k++) begin : g_ready
    assign ready[k] = !ctrl[k].valid || ready[k+1];
  end

  assign in_stall_o = !ready[0];

  rgbhsl_prep #(
    .CW (CW),
    .QW (QW)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ready_i   (ready[0]),
    .valid_i   (in_valid_i),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .thr_i     (thr_q),
    .ctrl_o    (ctrl[0]),
    .sum_o     (sum[0]),
    .sat_rem_o (sat_rem[0]),
    .sat_den_o (sat_den[0]),
    .sat_q_o   (sat_q[0]),
    .hue_rem_o (hue_rem[0]),
    .hue_div_o (hue_div[0]),
    .hue_q_o   (hue_q[0])
  );

  for (genvar k = 1; k <= NCELLS; k++) begin : g_cell
    rgbhsl_div_cell #(
      .CW (CW),
      .QW (QW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ready_i   (ready[k]),
      .ctrl_i    (ctrl[k-1]),
      .sum_i     (sum[k-1]),
      .sat_rem_i (sat_rem[k-1]),
      .sat_den_i (sat_den[k-1]),
      .sat_q_i   (sat_q[k-1]),
      .hue_rem_i (hue_rem[k-1]),
      .hue_div_i (hue_div[k-1]),
      .hue_q_i   (hue_q[k-1]),
      .ctrl_o    (ctrl[k]),
      .sum_o     (sum[k]),
      .sat_rem_o (sat_rem[k]),
      .sat_den_o (sat_den[k]),
      .sat_q_o   (sat_q[k]),
      .hue_rem_o (hue_rem[k]),
      .hue_div_o (hue_div[k]),
      .hue_q_o   (hue_q[k])
    );
  end

  // ---------------------------------------------------------------------
  // Final assembly into the output register
  // ---------------------------------------------------------------------
  rgbhsl_pkg::ctrl_t last;
  logic [SB:0]       sat_full;
  logic [SB-1:0]     sat_d;
  logic [FB:0]       hue_frac;
  logic [HW-1:0]     hue_base, hue_d;

  assign last = ctrl[NCELLS];

  always_comb begin
    // integer bit plus SB fraction bits; extra cells only shift in more
    sat_full = sat_q[NCELLS][QW-1 -: SB+1];
    sat_d    = sat_full[SB] ? {SB{1'b1}} : sat_full[SB-1:0];

    hue_frac = hue_q[NCELLS][QW-1 -: FB+1];
    case (last.sector)
      rgbhsl_pkg::SECT_RED:   hue_base = HW'(1) << FB;
      rgbhsl_pkg::SECT_GREEN: hue_base = HW'(3) << FB;
      rgbhsl_pkg::SECT_BLUE:  hue_base = HW'(5) << FB;
      default:                hue_base = '0;
    endcase
    // quotient magnitude is at most one, so the result never goes negative
    hue_d = last.neg ? (hue_base - HW'(hue_frac)) : (hue_base + HW'(hue_frac));

    if (last.gray) begin
      sat_d = '0;
      hue_d = '0;
    end
  end

  logic [HW-1:0] hue_q_out;
  logic [SB-1:0] sat_q_out;
  logic [CW:0]   sum_q_out;
  logic          gray_q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready[NCELLS+1]) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[NCELLS+1]) begin
      hue_q_out  <= hue_d;
      sat_q_out  <= sat_d;
      sum_q_out  <= sum[NCELLS];
      gray_q_out <= last.gray;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hue_o           = hue_q_out;
  assign saturation_o    = sat_q_out;
  assign lightness_sum_o = sum_q_out;
  assign is_gray_o       = gray_q_out;

endmodule
